>>> rtl/cdq_pkg.sv
// Shared types and constants for the circular deque with cursor.
// Holds the operation codes, status codes, controller states and the
// command/status structs. No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CUR_FRONT  = 3'd4,
    KIND_CUR_BACK   = 3'd5,
    KIND_CUR_NEXT   = 3'd6,
    KIND_CUR_PREV   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted transaction
    logic exec;     // update indices, write or issue a read
    logic load;     // fill the output register
  } cdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // output register empty or being drained
  } cdq_stat_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cdq_if.sv
// Valid/ready channel interfaces for the deque: operation in, result out.
// Depends on cdq_pkg for widths.
`default_nettype none

interface cdq_in_if
  import cdq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, kind, data_in, input ready);
  modport sink   (input valid, kind, data_in, output ready);
endinterface

interface cdq_out_if
  import cdq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic [1:0]        status;
  logic              is_empty;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, data_out, status, is_empty, entry_count, input ready);
  modport sink   (input valid, data_out, status, is_empty, entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/cdq_ctrl.sv
// Controller state machine for the deque: accept, execute, load result.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cdq_stat_t stat,
  output cdq_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_LOAD;
      S_LOAD: if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_LOAD: cmd.load = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/cdq_dp.sv
// Datapath for the deque: indices, cursor, ring memory and result register.
// Depends on cdq_pkg; driven by cdq_ctrl through cdq_cmd_t.
`default_nettype none

module cdq_dp
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_cmd_t          cmd,
  output cdq_stat_t         stat,
  input  logic [2:0]        in_kind,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic [1:0]        out_status,
  output logic              out_is_empty,
  output logic [CNT_W-1:0]  out_count
);

  logic [DATA_W-1:0] ring_mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;

  kind_t             kind_r;
  logic [DATA_W-1:0] data_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [IDX_W-1:0]  back_r, back_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic              cur_vld_r, cur_vld_nxt;
  logic              hit_r, hit_nxt;
  stat_t             stat_r, stat_nxt;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic              is_full, is_emp;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  stat_t             out_stat_r;
  logic              out_empty_r;
  logic [CNT_W-1:0]  out_count_r;

  assign is_full = (count_r == CNT_W'(DEPTH));
  assign is_emp  = (count_r == '0);

  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    hit_nxt     = hit_r;
    stat_nxt    = stat_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = '0;
    if (cmd.exec) begin
      hit_nxt  = 1'b0;
      stat_nxt = STAT_OK;
      unique case (kind_r) inside
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (is_full) begin
            stat_nxt = STAT_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (is_emp) begin
              waddr     = '0;
              front_nxt = IDX_W'(DEPTH - 1);
              back_nxt  = idx_inc('0);
            end else if (kind_r == KIND_PUSH_FRONT) begin
              waddr     = front_r;
              front_nxt = idx_dec(front_r);
            end else begin
              waddr    = back_r;
              back_nxt = idx_inc(back_r);
            end
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (is_emp) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            re        = 1'b1;
            hit_nxt   = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            if (kind_r == KIND_POP_FRONT) begin
              front_nxt = idx_inc(front_r);
              raddr     = front_nxt;
            end else begin
              back_nxt = idx_dec(back_r);
              raddr    = back_nxt;
            end
          end
        end
        KIND_CUR_FRONT, KIND_CUR_BACK: begin
          if (is_emp) begin
            cur_vld_nxt = 1'b0;
            stat_nxt    = STAT_EMPTY;
          end else begin
            cur_vld_nxt = 1'b1;
            cur_nxt     = (kind_r == KIND_CUR_FRONT) ? idx_inc(front_r) : idx_dec(back_r);
          end
        end
        default: begin
          // cursor next / previous
          if (!cur_vld_r) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            re      = 1'b1;
            hit_nxt = 1'b1;
            raddr   = cur_r;
            if (kind_r == KIND_CUR_NEXT) begin
              cur_nxt     = idx_inc(cur_r);
              cur_vld_nxt = (cur_nxt != back_r);
            end else begin
              cur_nxt     = idx_dec(cur_r);
              cur_vld_nxt = (cur_nxt != front_r);
            end
          end
        end
      endcase
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) ring_mem[waddr] <= data_r;
  end

  always_ff @(posedge clk) begin
    if (re) rd_q_r <= ring_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_kind);
      data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      back_r    <= '0;
      count_r   <= '0;
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      stat_r    <= STAT_OK;
    end else begin
      front_r   <= front_nxt;
      back_r    <= back_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      cur_vld_r <= cur_vld_nxt;
      hit_r     <= hit_nxt;
      stat_r    <= stat_nxt;
    end
  end

  // result register
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r  <= hit_r ? rd_q_r : '0;
      out_stat_r  <= stat_r;
      out_empty_r <= is_emp;
      out_count_r <= count_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_status   = out_stat_r;
  assign out_is_empty = out_empty_r;
  assign out_count    = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (kind_r == KIND_PUSH_FRONT || kind_r == KIND_PUSH_BACK) && !is_full
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted push did not add one entry");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (kind_r == KIND_POP_FRONT || kind_r == KIND_POP_BACK) && is_emp
    |=> count_r == '0 && $stable(front_r) && $stable(back_r))
    else $error("pop on empty deque changed state");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> stat.out_free)
    else $error("result register overwritten before taken");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_empty_r == (out_count_r == '0))
    else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

>>> rtl/circular_deque_with_cursor.sv
// Top level of the circular deque with traversal cursor.
// Depends on cdq_pkg, cdq_if (channels), cdq_ctrl and cdq_dp.
//
// A bounded double-ended ring of DEPTH entries with a cursor. Each input
// transaction carries one operation (push front/back, pop front/back, cursor
// to front/back, cursor next/previous) and yields exactly one result
// transaction with the popped or visited entry, a status (ok, full or empty;
// an invalid cursor reports empty), the empty flag and the entry count after
// the operation. Operations run one at a time: accept, execute against the
// indices and the ring memory, then load the result register. These steps
// follow the registered read of the ring memory: the execute step issues
// the read and the load step takes its data.
// The input side reopens as soon as the result is loaded, while that result
// still waits to be taken; a stalled output holds the next operation in its
// load step. Entries never pushed since reset must not be read by the cursor;
// their data is undefined. No clearing pass is needed after reset.
`default_nettype none

module circular_deque_with_cursor
  import cdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  cdq_in_if.sink           in_chan,
  cdq_out_if.source        out_chan
);

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  // sequence accept / execute / load
  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // indices, cursor, ring memory and result register
  cdq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_chan.kind),
    .in_data      (in_chan.data_in),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_data     (out_chan.data_out),
    .out_status   (out_chan.status),
    .out_is_empty (out_chan.is_empty),
    .out_count    (out_chan.entry_count)
  );

endmodule

`default_nettype wire
